[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/core/cdvc_pkg.sv]
// package: constants and types of the causal delivery block
package cdvc_pkg;
  localparam int unsigned NumProc    = 4;
  localparam int unsigned HoldDepth  = 16;
  localparam int unsigned ClockBits  = 16;
  localparam int unsigned IdW        = 2;
  localparam int unsigned HoldIdxW   = $clog2(HoldDepth);
  localparam int unsigned HoldCntW   = $clog2(HoldDepth + 1);
  localparam int unsigned EntryW     = IdW + 16 + NumProc * ClockBits;
  localparam logic [ClockBits-1:0] ClockMax = '1;

  typedef enum logic [1:0] {
    KindSent      = 2'd0,
    KindDelivered = 2'd1,
    KindHeld      = 2'd2,
    KindRejected  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StCheck,
    StFlush
  } state_e;

  typedef logic [ClockBits-1:0] stamp_t [NumProc];
endpackage

[rtl/core/cdvc_ram.sv]
// generic single-port-write ram with registered read
module cdvc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[rtl/core/causal_delivery_vector_clock.sv]
// top level: causal-order delivery with vector clocks and a hold store
// latency: a send, hold or reject shows its transfer the cycle after acceptance;
// a delivery first scans a non-empty hold store, reading then checking each entry,
// in passes until one delivers nothing or none remain; its last transfer is then flushed
// throughput: one item at a time, taken when idle with the result register empty
// reset: clocks, counts, sequence and hold fill count clear; ram contents undefined
module causal_delivery_vector_clock (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action_i,
  input  logic [1:0]  in_sender_i,
  input  logic [15:0] in_seq_i,
  input  logic [15:0] in_stamp_0_i,
  input  logic [15:0] in_stamp_1_i,
  input  logic [15:0] in_stamp_2_i,
  input  logic [15:0] in_stamp_3_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind_o,
  output logic [1:0]  out_sender_o,
  output logic [15:0] out_seq_o,
  output logic [15:0] out_stamp_0_o,
  output logic [15:0] out_stamp_1_o,
  output logic [15:0] out_stamp_2_o,
  output logic [15:0] out_stamp_3_o,
  output logic [15:0] delivered_total_o,
  output logic        last_o
);
  import cdvc_pkg::*;

  state_e state_q, state_d;
  logic [IdW-1:0] own_id_q;
  stamp_t clock_q, clock_d;
  logic [15:0] cnt_q [NumProc];
  logic [15:0] cnt_d [NumProc];
  logic [15:0] seq_q, seq_d;
  logic [HoldCntW-1:0] fill_q, fill_d;
  logic [HoldIdxW-1:0] idx_q, idx_d;
  logic [HoldCntW-1:0] wr_q, wr_d;
  logic any_q, any_d;

  // result register
  logic ov_q, ov_d;
  logic [1:0] okind_q, okind_d, osnd_q, osnd_d;
  logic [15:0] oseq_q, oseq_d, otot_q, otot_d;
  stamp_t ost_q, ost_d;
  logic olast_q, olast_d;

  // delivery held back until it is known whether another one follows
  logic [IdW-1:0] pd_snd_q, pd_snd_d;
  logic [15:0] pd_seq_q, pd_seq_d, pd_tot_q, pd_tot_d;
  stamp_t pd_st_q, pd_st_d;

  // ram signals
  logic ram_we;
  logic [HoldIdxW-1:0] ram_wa, ram_ra;
  logic [EntryW-1:0] ram_wd, ram_rd;

  cdvc_ram #(.Width(EntryW), .Depth(HoldDepth)) u_hold (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  // unpack the entry read back
  logic [IdW-1:0] rd_snd;
  logic [15:0] rd_seq;
  stamp_t rd_st, in_st;
  always_comb begin
    rd_snd = ram_rd[EntryW-1 -: IdW];
    rd_seq = ram_rd[EntryW-IdW-1 -: 16];
    for (int i = 0; i < NumProc; i++) rd_st[i] = ram_rd[i*ClockBits +: ClockBits];
    in_st[0] = in_stamp_0_i;
    in_st[1] = in_stamp_1_i;
    in_st[2] = in_stamp_2_i;
    in_st[3] = in_stamp_3_i;
  end

  function automatic logic deliv(logic [IdW-1:0] s, stamp_t st, stamp_t c);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NumProc; i++) begin
      if (IdW'(i) == s) begin
        if (c[i] == ClockMax || st[i] != c[i] + 1'b1) ok = 1'b0;
      end else if (st[i] > c[i]) ok = 1'b0;
    end
    return ok;
  endfunction

  logic in_fire, out_free;
  logic in_self, in_ok, hold_full, in_deliver;
  logic rd_ok, chk_go, pass_end, pass_any;
  logic [HoldCntW-1:0] idx_next, wr_nx;

  assign in_ready   = (state_q == StIdle) && !ov_q;
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !ov_q || out_ready;
  assign in_self    = (in_sender_i == own_id_q);
  assign in_ok      = deliv(in_sender_i, in_st, clock_q);
  assign hold_full  = (fill_q == HoldCntW'(HoldDepth));
  assign in_deliver = in_fire && action_i && !in_self && in_ok;

  // scan decisions for the entry read back
  assign rd_ok    = deliv(rd_snd, rd_st, clock_q);
  assign chk_go   = (state_q == StCheck) && (!rd_ok || out_free);
  assign idx_next = {1'b0, idx_q} + 1'b1;
  assign pass_end = (idx_next == fill_q);
  assign pass_any = any_q || rd_ok;
  assign wr_nx    = rd_ok ? wr_q : wr_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_deliver) state_d = (fill_q != '0) ? StRead : StFlush;
      end
      StRead: begin
        state_d = StCheck;
      end
      StCheck: begin
        if (chk_go) begin
          if (!pass_end) state_d = StRead;
          else if (pass_any && wr_nx != '0) state_d = StRead;
          else state_d = StFlush;
        end
      end
      StFlush: begin
        if (out_free) state_d = StIdle;
      end
    endcase
  end

  // datapath, ram access and result register
  always_comb begin
    clock_d = clock_q;
    cnt_d = cnt_q;
    seq_d = seq_q;
    fill_d = fill_q;
    idx_d = idx_q;
    wr_d = wr_q;
    any_d = any_q;
    ov_d = ov_q && !out_ready;
    okind_d = okind_q; osnd_d = osnd_q; oseq_d = oseq_q; otot_d = otot_q;
    ost_d = ost_q; olast_d = olast_q;
    pd_snd_d = pd_snd_q; pd_seq_d = pd_seq_q; pd_st_d = pd_st_q; pd_tot_d = pd_tot_q;
    ram_we = 1'b0;
    ram_wa = fill_q[HoldIdxW-1:0];
    ram_wd = {in_sender_i, in_seq_i, in_st[3], in_st[2], in_st[1], in_st[0]};
    ram_ra = idx_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (!action_i) begin
            if (clock_q[own_id_q] != ClockMax)
              clock_d[own_id_q] = clock_q[own_id_q] + 1'b1;
            ov_d = 1'b1; olast_d = 1'b1;
            okind_d = KindSent; osnd_d = own_id_q; oseq_d = seq_q;
            ost_d = clock_d; otot_d = '0;
            seq_d = seq_q + 1'b1;
          end else if (in_self || !in_ok) begin
            ov_d = 1'b1; olast_d = 1'b1;
            osnd_d = in_sender_i; oseq_d = in_seq_i; ost_d = in_st;
            otot_d = cnt_q[in_sender_i];
            if (in_self || hold_full) okind_d = KindRejected;
            else begin
              okind_d = KindHeld;
              ram_we = 1'b1;
              fill_d = fill_q + 1'b1;
            end
          end else begin
            for (int i = 0; i < NumProc; i++)
              if (in_st[i] > clock_q[i]) clock_d[i] = in_st[i];
            if (cnt_q[in_sender_i] != 16'hFFFF)
              cnt_d[in_sender_i] = cnt_q[in_sender_i] + 1'b1;
            pd_snd_d = in_sender_i; pd_seq_d = in_seq_i; pd_st_d = in_st;
            pd_tot_d = cnt_d[in_sender_i];
            idx_d = '0; wr_d = '0; any_d = 1'b0;
          end
        end
      end
      StRead: begin
        // address idx_q is presented to the ram this cycle
      end
      StCheck: begin
        if (chk_go) begin
          if (rd_ok) begin
            for (int i = 0; i < NumProc; i++)
              if (rd_st[i] > clock_q[i]) clock_d[i] = rd_st[i];
            if (cnt_q[rd_snd] != 16'hFFFF) cnt_d[rd_snd] = cnt_q[rd_snd] + 1'b1;
            // a further delivery follows, so the held-back one is not last
            ov_d = 1'b1; okind_d = KindDelivered; osnd_d = pd_snd_q;
            oseq_d = pd_seq_q; ost_d = pd_st_q; otot_d = pd_tot_q; olast_d = 1'b0;
            pd_snd_d = rd_snd; pd_seq_d = rd_seq; pd_st_d = rd_st;
            pd_tot_d = cnt_d[rd_snd];
          end else begin
            // keep the entry, packed down to the write position
            ram_we = 1'b1;
            ram_wa = wr_q[HoldIdxW-1:0];
            ram_wd = ram_rd;
          end
          if (pass_end) begin
            fill_d = wr_nx; idx_d = '0; wr_d = '0; any_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1; wr_d = wr_nx; any_d = pass_any;
          end
        end
      end
      StFlush: begin
        if (out_free) begin
          ov_d = 1'b1; okind_d = KindDelivered; osnd_d = pd_snd_q;
          oseq_d = pd_seq_q; ost_d = pd_st_q; otot_d = pd_tot_q; olast_d = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      own_id_q <= '0;
      for (int i = 0; i < NumProc; i++) begin
        clock_q[i] <= '0;
        cnt_q[i] <= '0;
      end
      seq_q <= '0;
      fill_q <= '0;
      idx_q <= '0;
      wr_q <= '0;
      any_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we) own_id_q <= cfg_wdata;
      state_q <= state_d;
      clock_q <= clock_d;
      cnt_q <= cnt_d;
      seq_q <= seq_d;
      fill_q <= fill_d;
      idx_q <= idx_d;
      wr_q <= wr_d;
      any_q <= any_d;
      ov_q <= ov_d;
    end
  end

  // result payload and held-back delivery
  always_ff @(posedge clk_i) begin
    okind_q <= okind_d; osnd_q <= osnd_d; oseq_q <= oseq_d; otot_q <= otot_d;
    ost_q <= ost_d; olast_q <= olast_d;
    pd_snd_q <= pd_snd_d; pd_seq_q <= pd_seq_d; pd_st_q <= pd_st_d;
    pd_tot_q <= pd_tot_d;
  end

  assign out_valid = ov_q;
  assign event_kind_o = okind_q;
  assign out_sender_o = osnd_q;
  assign out_seq_o = oseq_q;
  assign out_stamp_0_o = ost_q[0];
  assign out_stamp_1_o = ost_q[1];
  assign out_stamp_2_o = ost_q[2];
  assign out_stamp_3_o = ost_q[3];
  assign delivered_total_o = otot_q;
  assign last_o = olast_q;
endmodule

[rtl/core/cdvc_checker.sv]
// checker: port-level properties of the causal delivery block
`include "assert_macros.svh"
module cdvc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_kind_o,
  input logic        last_o
);
  import cdvc_pkg::*;
  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, out_valid, !in_ready)
  `ASSERT_IMPL(a_reject_last, clk_i, rst_ni, out_valid && event_kind_o == KindRejected, last_o)
  `ASSERT_IMPL(a_held_last, clk_i, rst_ni, out_valid && event_kind_o == KindHeld, last_o)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_one_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready)
endmodule

bind causal_delivery_vector_clock cdvc_checker u_cdvc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .event_kind_o(event_kind_o),
  .last_o(last_o)
);
